@@ hdl/bc_pkg.sv @@
package bc_pkg;

    // Index width of n and k
    localparam int INDEX_WIDTH = 6;
    // Width of the coefficient and of the product before the exact division
    localparam int COEF_W      = 60;
    localparam int PROD_W      = COEF_W + INDEX_WIDTH;

    // Step counters of the serial units
    localparam int MUL_CNT_W   = $clog2(INDEX_WIDTH);
    localparam int DIV_CNT_W   = $clog2(PROD_W);

    // Stream widths, rounded up to whole bytes
    localparam int IN_TDATA_W  = ((2 * INDEX_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((COEF_W + 1 + 7) / 8) * 8;

    // Multiplier request and response
    typedef struct packed {
        logic                    start;
        logic [COEF_W-1:0]       multiplicand;
        logic [INDEX_WIDTH-1:0]  multiplier;
    } mul_req_t;

    typedef struct packed {
        logic                    done;
        logic [PROD_W-1:0]       product;
    } mul_rsp_t;

    // Divider request and response
    typedef struct packed {
        logic                    start;
        logic [PROD_W-1:0]       dividend;
        logic [INDEX_WIDTH-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic [PROD_W-1:0]       quotient;
    } div_rsp_t;

endpackage

@@ hdl/bc_mul.sv @@
module bc_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  bc_pkg::mul_req_t  req,
    output bc_pkg::mul_rsp_t  rsp
);

    localparam logic [bc_pkg::MUL_CNT_W-1:0] LAST_STEP =
        bc_pkg::MUL_CNT_W'(bc_pkg::INDEX_WIDTH - 1);

    logic                             busy_reg;
    logic                             done_reg;
    logic [bc_pkg::MUL_CNT_W-1:0]     cnt_reg;
    logic [bc_pkg::PROD_W-1:0]        prod_reg;
    logic [bc_pkg::PROD_W-1:0]        mcand_reg;
    logic [bc_pkg::INDEX_WIDTH-1:0]   mplier_reg;

    // Sequence one multiplier bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift-add: add the shifted multiplicand when the low multiplier bit is set
    always_ff @(posedge aclk) begin
        if (req.start) begin
            prod_reg   <= '0;
            mcand_reg  <= bc_pkg::PROD_W'(req.multiplicand);
            mplier_reg <= req.multiplier;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                prod_reg <= prod_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = prod_reg;

endmodule

@@ hdl/bc_div.sv @@
module bc_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  bc_pkg::div_req_t  req,
    output bc_pkg::div_rsp_t  rsp
);

    localparam logic [bc_pkg::DIV_CNT_W-1:0] LAST_STEP =
        bc_pkg::DIV_CNT_W'(bc_pkg::PROD_W - 1);

    logic                             busy_reg;
    logic                             done_reg;
    logic [bc_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [bc_pkg::INDEX_WIDTH-1:0]   rem_reg;
    logic [bc_pkg::INDEX_WIDTH-1:0]   dvsr_reg;
    logic [bc_pkg::PROD_W-1:0]        quo_reg;

    logic [bc_pkg::INDEX_WIDTH:0]     trial;
    logic [bc_pkg::INDEX_WIDTH:0]     diff;
    logic                             fits;

    // Bring down the next dividend bit and try the subtraction
    always_comb begin
        trial = {rem_reg, quo_reg[bc_pkg::PROD_W-1]};
        diff  = trial - {1'b0, dvsr_reg};
        fits  = (trial >= {1'b0, dvsr_reg});
    end

    // Sequence one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Dividend shifts out at the top while quotient bits shift in at the bottom
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg  <= '0;
            dvsr_reg <= req.divisor;
            quo_reg  <= req.dividend;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[bc_pkg::INDEX_WIDTH-1:0]
                            : trial[bc_pkg::INDEX_WIDTH-1:0];
            quo_reg <= {quo_reg[bc_pkg::PROD_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ hdl/binomial_coefficient.sv @@
// Binomial coefficient C(n,k) by the multiplicative rule. The block takes one
// beat with n and k, folds k to n-k when k is above n/2, then runs k steps,
// each multiplying the running value by (n-i) with a bit-serial shift-add
// multiplier (one bit of the 6-bit factor per cycle) and dividing it exactly by
// (i+1) with a restoring divider that handles one bit of the 66-bit product per
// cycle. When k is above n the result is 0 with bad_arguments set, and k = 0 or
// k = n gives 1, with no steps run. A new item is taken as soon as the previous
// one has left the sequencer, while its result may still wait in the output
// register.
module binomial_coefficient (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // n_value [5:0], k_value [11:6], zeros above
    input  logic [bc_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // coefficient [59:0], bad_arguments [60], zeros above
    output logic [bc_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    localparam int W = bc_pkg::INDEX_WIDTH;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_MUL    = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    logic [W-1:0]                 n_reg, n_next;
    logic [W-1:0]                 k_reg, k_next;
    logic [W-1:0]                 i_reg, i_next;
    logic [bc_pkg::COEF_W-1:0]    acc_reg, acc_next;
    logic                         bad_reg, bad_next;
    logic                         out_valid_reg, out_valid_next;
    logic [bc_pkg::COEF_W-1:0]    out_coef_reg;
    logic                         out_bad_reg;

    logic                         accept;
    logic                         load_out;
    logic [W-1:0]                 n_in, k_in, k_fold;
    logic [W-1:0]                 step_inc;

    bc_pkg::mul_req_t             mul_req;
    bc_pkg::mul_rsp_t             mul_rsp;
    bc_pkg::div_req_t             div_req;
    bc_pkg::div_rsp_t             div_rsp;

    bc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    bc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Unpack the input beat and fold k to the smaller half
    assign n_in     = s_tdata[W-1:0];
    assign k_in     = s_tdata[2*W-1:W];
    assign k_fold   = (k_in > (n_in >> 1)) ? (n_in - k_in) : k_in;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign step_inc = i_reg + 1'b1;
    assign load_out = (state_reg == ST_FINISH) && (!out_valid_reg || m_tready);

    // Launch a multiply on a new item that has steps to run or after a division that leaves steps to go
    always_comb begin
        mul_req.start = (accept && (k_in <= n_in) && (k_fold != '0)) ||
                        ((state_reg == ST_DIV) && div_rsp.done && (step_inc != k_reg));
        if (state_reg == ST_IDLE) begin
            mul_req.multiplicand = bc_pkg::COEF_W'(1);
            mul_req.multiplier   = n_in;
        end else begin
            mul_req.multiplicand = div_rsp.quotient[bc_pkg::COEF_W-1:0];
            mul_req.multiplier   = n_reg - step_inc;
        end
    end

    // Divide each product exactly by the step number plus one
    always_comb begin
        div_req.start    = (state_reg == ST_MUL) && mul_rsp.done;
        div_req.dividend = mul_rsp.product;
        div_req.divisor  = step_inc;
    end

    // Step sequencer
    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        acc_next   = acc_reg;
        bad_next   = bad_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    n_next = n_in;
                    k_next = k_fold;
                    i_next = '0;
                    if (k_in > n_in) begin
                        acc_next   = '0;
                        bad_next   = 1'b1;
                        state_next = ST_FINISH;
                    end else if (k_fold == '0) begin
                        acc_next   = bc_pkg::COEF_W'(1);
                        bad_next   = 1'b0;
                        state_next = ST_FINISH;
                    end else begin
                        bad_next   = 1'b0;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                if (mul_rsp.done) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    acc_next = div_rsp.quotient[bc_pkg::COEF_W-1:0];
                    i_next   = step_inc;
                    state_next = (step_inc == k_reg) ? ST_FINISH : ST_MUL;
                end
            end
            ST_FINISH: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result beat until the downstream side takes it
    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        if (load_out) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg   <= n_next;
        k_reg   <= k_next;
        acc_reg <= acc_next;
        bad_reg <= bad_next;
        if (load_out) begin
            out_coef_reg <= acc_reg;
            out_bad_reg  <= bad_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(bc_pkg::OUT_TDATA_W - bc_pkg::COEF_W - 1){1'b0}},
                       out_bad_reg, out_coef_reg};

    // A multiply completes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.done |-> (state_reg == ST_MUL))
        else $error("multiplier finished outside the multiply phase");

    // A division completes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide phase");

    // The step index stays below the folded k while steps run
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_MUL) || (state_reg == ST_DIV)) |-> (i_reg < k_reg))
        else $error("step index ran past k");

    // Bad arguments always come with a zero coefficient
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_bad_reg) |-> (out_coef_reg == '0))
        else $error("nonzero coefficient flagged as bad");

endmodule

@@ tb/tb_binomial_coefficient.sv @@
module tb_binomial_coefficient;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IW     = bc_pkg::INDEX_WIDTH;
    localparam int CW     = bc_pkg::COEF_W;
    localparam int IN_W   = bc_pkg::IN_TDATA_W;
    localparam int OUT_W  = bc_pkg::OUT_TDATA_W;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int HOLD_AT        = 50;
    localparam int HOLD_LEN       = 8000;
    localparam int TAIL_CYCLES    = 2400;
    localparam int ITEMS_PER_PHASE = 62;

    localparam int DIR_CNT = 20;
    int dir_n [DIR_CNT] = '{ 0, 63, 63,  0, 63, 63, 62, 1, 1, 1,
                            62, 63,  2, 40, 63, 10, 32, 5, 0, 63};
    int dir_k [DIR_CNT] = '{ 0, 63,  0, 63, 31, 32, 31, 0, 1, 2,
                            63, 62,  1, 20,  1,  3, 16, 6, 1, 61};

    typedef struct {
        logic [CW-1:0] coefficient;
        logic          bad_arguments;
    } binom_t;

    // C(n,k) by the multiplicative rule, k folded to n-k above n/2
    function automatic logic [CW-1:0] binom_of(logic [IW-1:0] n, logic [IW-1:0] k);
        logic [IW-1:0]  kk;
        logic [127:0]   acc;
        kk  = (k > n / 2) ? n - k : k;
        acc = 128'd1;
        for (int i = 0; i < int'(kk); i++)
            acc = (acc * 128'(int'(n) - i)) / 128'(i + 1);
        return acc[CW-1:0];
    endfunction

    class binom_tracker;
        binom_t pending_binoms[$];
        int     fail_count = 0;

        function void report(string what);
            fail_count++;
            if (fail_count <= 10)
                $display("%0t ns: %s", $time, what);
        endfunction

        // queue the coefficient expected for an accepted operand beat
        function void note_operands(logic [IW-1:0] n, logic [IW-1:0] k);
            binom_t e;
            if (k > n) begin
                e.coefficient   = '0;
                e.bad_arguments = 1'b1;
            end else begin
                e.coefficient   = binom_of(n, k);
                e.bad_arguments = 1'b0;
            end
            pending_binoms.push_back(e);
        endfunction

        // compare a result beat against the oldest expected coefficient
        function void check_beat(logic [OUT_W-1:0] beat);
            binom_t e;
            if (pending_binoms.size() == 0) begin
                report($sformatf("unexpected result beat %h", beat));
                return;
            end
            e = pending_binoms.pop_front();
            if (beat[CW-1:0] !== e.coefficient)
                report($sformatf("coefficient expected %0d got %0d",
                                 e.coefficient, beat[CW-1:0]));
            if (beat[CW] !== e.bad_arguments)
                report($sformatf("bad_arguments expected %0b got %0b",
                                 e.bad_arguments, beat[CW]));
        endfunction

        function int pending();
            return pending_binoms.size();
        endfunction
    endclass

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    // n_value [5:0], k_value [11:6], zeros above
    logic [IN_W-1:0]   s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // coefficient [59:0], bad_arguments [60], zeros above
    logic [OUT_W-1:0]  m_tdata;

    binom_tracker tracker = new();

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int in_beats     = 0;
    int stall_cycles = 0;
    int hold_left    = 0;
    bit hold_used    = 1'b0;

    binomial_coefficient uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // receiver: random stalls, plus one long hold-off once traffic is flowing
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_used && in_beats >= HOLD_AT) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_LEN;
            hold_used <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // monitor both channels and count cycles with no beat moving
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tracker.note_operands(s_tdata[IW-1:0], s_tdata[2*IW-1:IW]);
                in_beats <= in_beats + 1;
            end
            if (m_tvalid && m_tready)
                tracker.check_beat(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : watchdog
        while (stall_cycles < WATCHDOG_LIMIT)
            @(posedge aclk);
        $display("CHECK FAILED");
        $finish;
    end

    // offer one operand beat after a random gap and hold it until taken
    task automatic send_pair(input logic [IW-1:0] n, input logic [IW-1:0] k);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({k, n});
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    // mostly valid pairs, some with k above n, some at k = 0 or k = n
    task automatic send_random();
        logic [IW-1:0] n;
        logic [IW-1:0] k;
        int            pick;
        n    = IW'($urandom_range(63));
        pick = $urandom_range(99);
        if (pick < 20 && n != 63)
            k = IW'($urandom_range(63, int'(n) + 1));
        else if (pick < 30)
            k = $urandom_range(1) ? '0 : n;
        else
            k = IW'($urandom_range(int'(n)));
        send_pair(n, k);
    endtask

    // drop valid and wait until every queued coefficient has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners with no idling
        for (int i = 0; i < DIR_CNT; i++)
            send_pair(IW'(dir_n[i]), IW'(dir_k[i]));
        drain();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 87; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 87; end
                default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_random();
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (tracker.fail_count == 0 && tracker.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hdl/bc_pkg.sv
hdl/bc_mul.sv
hdl/bc_div.sv
hdl/binomial_coefficient.sv
tb/tb_binomial_coefficient.sv
